// ===== hw/rtl/heightfield_vertex_normal_unit_macros.svh =====
// Assertion macros for the height-field vertex normal unit.
// Used by the controller and the datapath; expects clock and reset in scope.
`ifndef HEIGHTFIELD_VERTEX_NORMAL_UNIT_MACROS_SVH
`define HEIGHTFIELD_VERTEX_NORMAL_UNIT_MACROS_SVH

// A property checked at every rising edge outside reset.
`define HVN_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A same-cycle implication checked at every rising edge outside reset.
`define HVN_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/hvn_pkg.sv =====
// Shared types and constants for the height-field vertex normal unit.
// No dependencies; imported by every module of the block.
package hvn_pkg;

   localparam int FRAC_BITS = 14;
   localparam int MAX_TILES = 4096;
   localparam int CFG_W     = 13;
   localparam int COORD_W   = 13;
   localparam int NORM_W    = 16;
   localparam int SUM_W     = 19;
   localparam int SQ_W      = 2 * SUM_W;
   localparam int Q_W       = SQ_W + 1;
   localparam int R_W       = SQ_W + 2 * FRAC_BITS + 2;
   localparam int WIDE_W    = Q_W + 2 * FRAC_BITS + 7;
   localparam int BIT_W     = $clog2(FRAC_BITS + 1);
   localparam int N_W       = FRAC_BITS + 2;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   // Register indexes, decoded from the word address.
   localparam logic REG_TILE_WIDTH  = 1'b0;
   localparam logic REG_TILE_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] TILE_RESET = CFG_W'(64);

   typedef struct packed {
      logic [COORD_W-1:0]       vertex_x;
      logic [COORD_W-1:0]       vertex_y;
      logic [1:0]               quadrant;
      logic                     cliff;
      logic                     neg_diag;
      logic signed [NORM_W-1:0] left_nx;
      logic signed [NORM_W-1:0] left_ny;
      logic signed [NORM_W-1:0] left_nz;
      logic signed [NORM_W-1:0] right_nx;
      logic signed [NORM_W-1:0] right_ny;
      logic signed [NORM_W-1:0] right_nz;
      logic                     last_tile;
   } req_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             accept;
      logic             q_clr;
      logic             q_add;
      logic             load;
      logic             step_a;
      logic             step_b;
      logic             store;
      logic             set_unit;
      logic             publish;
      logic [1:0]       comp;
      logic [BIT_W-1:0] bit_idx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic q_zero;
   } sts_type;

endpackage

// ===== hw/rtl/heightfield_vertex_normal_unit.sv =====
// Height-field vertex normal unit: top level with the register port.
// Depends on hvn_pkg, hvn_ctrl and hvn_dpath.
//
// Tile items of a vertex are summed in one cycle each while the unit is
// idle. On the item marked last_tile the unit squares the three sums one
// after another on one multiplier, then scales each component in turn
// with a bit-serial restoring search over FRAC_BITS+1 result bits, each
// bit passing through ST_STA and then ST_STB, all before the next item
// is taken. A zero sum skips the search. The result waits in an output
// register; the unit only stays in its final state, holding off further
// items, while the previous result is still not taken. Registers:
// tile_width at 0x0, tile_height at 0x4.
module heightfield_vertex_normal_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  hvn_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output hvn_pkg::rsp_type           rsp_data,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [hvn_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [hvn_pkg::DATA_W-1:0] csr_pwdata,
   output logic [hvn_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   import hvn_pkg::*;

   logic [CFG_W-1:0] tile_width_ff, tile_width_in;
   logic [CFG_W-1:0] tile_height_ff, tile_height_in;
   logic             wr_en;
   logic             reg_sel;
   cmd_type          cmd;
   sts_type          sts;

   // Register writes complete in the access phase.
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      tile_width_in  = tile_width_ff;
      tile_height_in = tile_height_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_TILE_WIDTH:  tile_width_in  = csr_pwdata[CFG_W-1:0];
            REG_TILE_HEIGHT: tile_height_in = csr_pwdata[CFG_W-1:0];
            default:         tile_width_in  = tile_width_ff;
         endcase
      end
      unique case (reg_sel)
         REG_TILE_WIDTH:  csr_prdata = DATA_W'(tile_width_ff);
         REG_TILE_HEIGHT: csr_prdata = DATA_W'(tile_height_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff  <= TILE_RESET;
         tile_height_ff <= TILE_RESET;
      end else begin
         tile_width_ff  <= tile_width_in;
         tile_height_ff <= tile_height_in;
      end
   end

   hvn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_tile),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hvn_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .tile_width  (tile_width_ff),
      .tile_height (tile_height_ff),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== hw/rtl/hvn_ctrl.sv =====
// Sequencing controller of the vertex normal unit.
// Depends on hvn_pkg and the assertion macro header.
`include "heightfield_vertex_normal_unit_macros.svh"

module hvn_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  hvn_pkg::sts_type sts,
   output hvn_pkg::cmd_type cmd
);
   import hvn_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SQ    = 3'd1;
   localparam logic [2:0] ST_CHK   = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_STA   = 3'd4;
   localparam logic [2:0] ST_STB   = 3'd5;
   localparam logic [2:0] ST_STORE = 3'd6;
   localparam logic [2:0] ST_FIN   = 3'd7;

   localparam logic [1:0]       COMP_LAST = 2'd2;
   localparam logic [BIT_W-1:0] BIT_TOP   = BIT_W'(FRAC_BITS);

   logic [2:0]       state_ff, state_in;
   logic [1:0]       comp_ff, comp_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             take;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign take      = req_valid && req_ready;

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      comp_in      = comp_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.comp     = comp_ff;
      cmd.bit_idx  = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = take;
            if (take && req_last) begin
               state_in = ST_SQ;
               comp_in  = '0;
            end
         end
         ST_SQ: begin
            cmd.q_clr = (comp_ff == '0);
            cmd.q_add = 1'b1;
            if (comp_ff == COMP_LAST) begin
               state_in = ST_CHK;
               comp_in  = '0;
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         ST_CHK: begin
            if (sts.q_zero) begin
               cmd.set_unit = 1'b1;
               state_in     = ST_FIN;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            bit_in   = BIT_TOP;
            state_in = ST_STA;
         end
         ST_STA: begin
            cmd.step_a = 1'b1;
            state_in   = ST_STB;
         end
         ST_STB: begin
            cmd.step_b = 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_STORE;
            end else begin
               bit_in   = bit_ff - BIT_W'(1);
               state_in = ST_STA;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (comp_ff == COMP_LAST) begin
               state_in = ST_FIN;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_LOAD;
            end
         end
         ST_FIN: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         comp_ff      <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         comp_ff      <= comp_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `HVN_ASSERT_IMP(a_pub_free, cmd.publish, !rsp_valid_ff || rsp_ready, "result overwritten")
   `HVN_ASSERT(a_last_starts, (take && req_last) |=> (state_ff == ST_SQ), "no finish started")
   `HVN_ASSERT(a_pub_valid, cmd.publish |=> rsp_valid_ff, "published result not shown")

endmodule

// ===== hw/rtl/hvn_dpath.sv =====
// Datapath of the vertex normal unit: tile accumulation and bit-serial
// normalization. Depends on hvn_pkg and the assertion macro header.
`include "heightfield_vertex_normal_unit_macros.svh"

module hvn_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  hvn_pkg::req_type          req_data,
   input  logic [hvn_pkg::CFG_W-1:0] tile_width,
   input  logic [hvn_pkg::CFG_W-1:0] tile_height,
   input  hvn_pkg::cmd_type          cmd,
   output hvn_pkg::sts_type          sts,
   output hvn_pkg::rsp_type          rsp_data
);
   import hvn_pkg::*;

   localparam logic [1:0] MODE_BOTH  = 2'd0;
   localparam logic [1:0] MODE_LEFT  = 2'd1;
   localparam logic [1:0] MODE_RIGHT = 2'd2;

   localparam logic [1:0] QUAD_UL = 2'd0;
   localparam logic [1:0] QUAD_SAME = 2'd1;
   localparam logic [1:0] QUAD_RU = 2'd2;
   localparam logic [1:0] QUAD_LEFT = 2'd3;

   localparam logic [CFG_W-1:0] TILE_MAX = CFG_W'(MAX_TILES);
   localparam logic [N_W-1:0]   N_ONE    = N_W'(1) << FRAC_BITS;

   logic signed [SUM_W-1:0]  sum_ff [3];
   logic signed [SUM_W-1:0]  sum_in [3];
   logic signed [NORM_W-1:0] lv [3];
   logic signed [NORM_W-1:0] rv [3];
   logic signed [16:0]       dv [3];
   logic [CFG_W-1:0]         tw, th;
   logic                     in_extent;
   logic [1:0]               mode;
   logic                     x_pos, y_pos, x_low, y_low;

   logic signed [SUM_W-1:0]  sel;
   logic [SUM_W-1:0]         abs_sel;
   logic [SQ_W-1:0]          sq;
   logic [Q_W-1:0]           q_ff;
   logic [R_W-1:0]           r_ff;
   logic signed [WIDE_W-1:0] u2_ff, uq_ff, t1_ff;
   logic signed [WIDE_W-1:0] qw, trial;
   logic                     fits;
   logic [N_W-1:0]           n_ff;
   logic                     neg_ff;
   logic [NORM_W-1:0]        res_ff [3];
   logic [NORM_W-1:0]        scaled;
   rsp_type                  out_ff;

   // Tile extent test and contribution mode.
   always_comb begin
      tw    = (tile_width > TILE_MAX) ? TILE_MAX : tile_width;
      th    = (tile_height > TILE_MAX) ? TILE_MAX : tile_height;
      x_pos = (req_data.vertex_x != '0);
      y_pos = (req_data.vertex_y != '0);
      x_low = (req_data.vertex_x < tw);
      y_low = (req_data.vertex_y < th);
      unique case (req_data.quadrant)
         QUAD_UL: begin
            in_extent = x_pos && y_pos;
            mode      = req_data.neg_diag ? MODE_RIGHT : MODE_BOTH;
         end
         QUAD_SAME: begin
            in_extent = x_low && y_low;
            mode      = req_data.neg_diag ? MODE_LEFT : MODE_BOTH;
         end
         QUAD_RU: begin
            in_extent = x_low && y_pos;
            mode      = req_data.neg_diag ? MODE_BOTH : MODE_LEFT;
         end
         QUAD_LEFT: begin
            in_extent = x_pos && y_low;
            mode      = req_data.neg_diag ? MODE_BOTH : MODE_RIGHT;
         end
         default: begin
            in_extent = 1'b0;
            mode      = MODE_BOTH;
         end
      endcase
   end

   // Contribution in half-LSB units and the running sums.
   always_comb begin
      lv[0] = req_data.left_nx;
      lv[1] = req_data.left_ny;
      lv[2] = req_data.left_nz;
      rv[0] = req_data.right_nx;
      rv[1] = req_data.right_ny;
      rv[2] = req_data.right_nz;
      for (int i = 0; i < 3; i++) begin
         unique case (mode)
            MODE_LEFT:  dv[i] = {lv[i], 1'b0};
            MODE_RIGHT: dv[i] = {rv[i], 1'b0};
            default:    dv[i] = {lv[i][NORM_W-1], lv[i]} + {rv[i][NORM_W-1], rv[i]};
         endcase
         sum_in[i] = sum_ff[i];
         if (cmd.publish) begin
            sum_in[i] = '0;
         end else if (cmd.accept && in_extent && !req_data.cliff) begin
            sum_in[i] = sum_ff[i] + {{(SUM_W-17){dv[i][16]}}, dv[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
   end

   // Selected component magnitude and its square.
   always_comb begin
      unique case (cmd.comp)
         2'd0:    sel = sum_ff[0];
         2'd1:    sel = sum_ff[1];
         default: sel = sum_ff[2];
      endcase
      abs_sel = sel[SUM_W-1] ? SUM_W'(-sel) : SUM_W'(sel);
      sq      = SQ_W'(abs_sel) * SQ_W'(abs_sel);
   end

   // One restoring step: test trial bit b with (2c-1)^2 * q <= a^2 * 2^(2F+2),
   // where the square is kept up to date by shifts and adds only.
   always_comb begin
      qw     = $signed({{(WIDE_W-Q_W){1'b0}}, q_ff});
      trial  = t1_ff + (qw <<< ({1'b0, cmd.bit_idx, 1'b0} + (BIT_W+2)'(2)));
      fits   = (trial <= $signed({{(WIDE_W-R_W){1'b0}}, r_ff}));
      scaled = neg_ff ? NORM_W'(-n_ff) : NORM_W'(n_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.q_add) begin
         q_ff <= cmd.q_clr ? Q_W'(sq) : q_ff + Q_W'(sq);
      end
      if (cmd.load) begin
         r_ff   <= {sq, {(2*FRAC_BITS+2){1'b0}}};
         neg_ff <= sel[SUM_W-1];
         u2_ff  <= qw;
         uq_ff  <= -qw;
         n_ff   <= '0;
      end
      if (cmd.step_a) begin
         t1_ff <= u2_ff + (uq_ff <<< ({1'b0, cmd.bit_idx} + (BIT_W+1)'(2)));
      end
      if (cmd.step_b && fits) begin
         u2_ff <= trial;
         uq_ff <= uq_ff + (qw <<< ({1'b0, cmd.bit_idx} + (BIT_W+1)'(1)));
         n_ff  <= n_ff | (N_W'(1) << cmd.bit_idx);
      end
      if (cmd.store) begin
         res_ff[cmd.comp] <= scaled;
      end
      if (cmd.set_unit) begin
         res_ff[0] <= '0;
         res_ff[1] <= '0;
         res_ff[2] <= NORM_W'(N_ONE);
      end
      if (cmd.publish) begin
         out_ff.normal_x <= res_ff[0];
         out_ff.normal_y <= res_ff[1];
         out_ff.normal_z <= res_ff[2];
      end
   end

   assign sts.q_zero = (q_ff == '0);
   assign rsp_data   = out_ff;

   `HVN_ASSERT(a_sum_clear, cmd.publish |=> (sum_ff[0] == '0 && sum_ff[1] == '0 && sum_ff[2] == '0), "sums not cleared")
   `HVN_ASSERT_IMP(a_n_range, cmd.store, n_ff <= N_ONE, "scaled component above one")
   `HVN_ASSERT_IMP(a_unit_zero, cmd.set_unit, q_ff == '0, "default normal on a nonzero sum")

endmodule
